// File: rtl/gbt_pkg.sv
// Shared constants and widths of the gesture box tracking controller.
package gbt_pkg;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// interpolation divider: dividend, divisor and quotient widths
	localparam int DIV_Q_W = 12;
	localparam int DIV_D_W = 17;
	localparam int DIV_N_W = DIV_D_W + DIV_Q_W;

	// request op codes
	localparam logic [1:0] OP_BOX     = 2'd0;
	localparam logic [1:0] OP_EMPTY   = 2'd1;
	localparam logic [1:0] OP_HOME    = 2'd2;
	localparam logic [1:0] OP_IGNORED = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_PAN_DZ    = 3'd0;
	localparam logic [2:0] CFG_START_BND = 3'd1;
	localparam logic [2:0] CFG_TGT_SIZE  = 3'd2;
	localparam logic [2:0] CFG_SIZE_DZ   = 3'd3;
	localparam logic [2:0] CFG_SETTLE    = 3'd4;
	localparam logic [2:0] CFG_MOVE_DUR  = 3'd5;
	localparam logic [2:0] CFG_SRC_W     = 3'd6;
	localparam logic [2:0] CFG_SRC_H     = 3'd7;

	// servo pulse limits and fixed move lengths
	localparam logic [11:0] PULSE_HOME = 12'd1500;
	localparam logic [11:0] PULSE_LOW  = 12'd500;
	localparam logic [11:0] PULSE_HIGH = 12'd2500;
	localparam logic [15:0] HOLD_MS    = 16'd20;
	localparam logic [15:0] HOME_MS    = 16'd500;

	// chassis direction codes
	localparam logic signed [1:0] DIR_NONE = 2'sb00;
	localparam logic signed [1:0] DIR_POS  = 2'sb01;
	localparam logic signed [1:0] DIR_NEG  = 2'sb11;

endpackage

// File: rtl/gbt_item_if.sv
// Input channel: detection box, empty frame and home requests.
interface gbt_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] box_x;
	logic [15:0] box_y;
	logic [15:0] box_w;
	logic [15:0] box_h;
	logic        last_box;
	logic [31:0] now_ms;

	modport source(output valid, op, box_x, box_y, box_w, box_h, last_box, now_ms,
		input ready);
	modport sink(input valid, op, box_x, box_y, box_w, box_h, last_box, now_ms,
		output ready);
endinterface

// File: rtl/gbt_result_if.sv
// Output channel: servo and chassis command results.
interface gbt_result_if;
	logic               valid;
	logic               ready;
	logic               servo_cmd_valid;
	logic [11:0]        servo_goal_us;
	logic [15:0]        servo_move_ms;
	logic               chassis_cmd_valid;
	logic signed [1:0]  drive_dir;
	logic signed [1:0]  steer_dir;
	logic [11:0]        servo_estimate_us;

	modport source(output valid, servo_cmd_valid, servo_goal_us, servo_move_ms,
		chassis_cmd_valid, drive_dir, steer_dir, servo_estimate_us, input ready);
	modport sink(input valid, servo_cmd_valid, servo_goal_us, servo_move_ms,
		chassis_cmd_valid, drive_dir, steer_dir, servo_estimate_us, output ready);
endinterface

// File: rtl/gesture_box_tracking_controller.sv
// Top level of the gesture box tracking controller: sequencer, state and ports.
//
// Usage. The item channel takes requests: op 0 is one detection box of a frame
// (last_box marks the frame's final box), op 1 an empty frame, op 2 a return of
// the tilt servo to home, op 3 is dropped. A box that is not last is only
// gathered (largest area wins, first on ties) and gives no result. A frame end,
// an empty frame or a home request gives one result on the result channel:
// servo command, chassis direction change and the interpolated servo estimate.
// Work per request: a home request goes straight to the result register; a box
// passes the area and best steps; an empty frame passes the servo estimate; a
// frame end passes both and then the 12 geometry products, made on one shared
// 34x16 multiplier once per cycle. A bit-serial divider rounds the estimate.
// Ready is high only while the sequencer is idle, so one request is in work at a
// time. The finished result sits in an output register; the next request is
// taken while it waits, and a later result waits until the receiver takes it.
// Reset (arst_n low) loads register defaults, centers the servo state at 1500 us,
// stops the chassis and empties the result register. The user must write configuration
// via cfg_we, cfg_index, cfg_data only while no request is in work (not enforced).
module gesture_box_tracking_controller import gbt_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 400,
	parameter int DISPLAY_HEIGHT = 320,
	parameter int FRAC_BITS      = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	gbt_item_if.sink      item,
	gbt_result_if.source  result,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam logic [MUL_B_W-1:0] DW = MUL_B_W'(DISPLAY_WIDTH);
	localparam logic [MUL_B_W-1:0] DH = MUL_B_W'(DISPLAY_HEIGHT);

	// geometry sequence: step names tell which product is issued
	localparam logic [3:0] GS_EY  = 4'd0;
	localparam logic [3:0] GS_EX  = 4'd1;
	localparam logic [3:0] GS_DZY = 4'd2;
	localparam logic [3:0] GS_DZX = 4'd3;
	localparam logic [3:0] GS_SBY = 4'd4;
	localparam logic [3:0] GS_GW0 = 4'd5;
	localparam logic [3:0] GS_GW1 = 4'd6;
	localparam logic [3:0] GS_GH0 = 4'd7;
	localparam logic [3:0] GS_GH1 = 4'd8;
	localparam logic [3:0] GS_SS  = 4'd9;
	localparam logic [3:0] GS_TSS = 4'd10;
	localparam logic [3:0] GS_DZS = 4'd11;
	localparam logic [3:0] GS_END = 4'd12;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AREA,
		ST_BEST,
		ST_EST,
		ST_EST_MUL,
		ST_EST_DIV,
		ST_GEO,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [3:0] step_q;

	// configuration registers
	logic [7:0]  pan_dz_q, start_band_q, size_dz_q;
	logic [9:0]  target_size_q;
	logic [15:0] settle_q, move_dur_q;
	logic [11:0] src_w_q, src_h_q;

	// request being worked on
	logic [1:0]  op_q;
	logic [15:0] cur_x_q, cur_y_q, cur_w_q, cur_h_q;
	logic        last_q;
	logic [31:0] now_q;

	// frame gathering
	logic [31:0] top_area_q;
	logic        has_box_q;
	logic [15:0] bx_q, by_q, bw_q, bh_q;

	// tilt servo state
	logic [11:0] pos_q, origin_q, goal_q;
	logic [31:0] mst_q, stop_time_q;
	logic [15:0] mlen_q;
	logic        moving_q, stop_pend_q, dneg_q;

	// chassis state and command flags
	logic signed [1:0] drive_q, steer_q;
	logic        srv_cmd_q, chs_cmd_q;
	logic [15:0] srv_ms_q;

	// geometry products
	logic [32:0] ey_mag_q, ex_mag_q, ss_q;
	logic [28:0] dzy_q, dzx_q, sby_q;
	logic [40:0] g_q, dzs_q;
	logic [42:0] tss_q;

	// result register
	logic              res_valid_q, res_srv_q, res_chs_q;
	logic [11:0]       res_goal_q, res_est_q;
	logic [15:0]       res_ms_q;
	logic signed [1:0] res_drive_q, res_steer_q;
	logic              emit_fire;

	// shared units
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;
	logic               div_start, div_done;
	logic [DIV_N_W-1:0] div_num;
	logic [DIV_D_W-1:0] div_den;
	logic [DIV_Q_W-1:0] div_quo;

	gbt_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	gbt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	function automatic logic [11:0] clamp_pulse(input logic signed [13:0] v);
		logic [11:0] r;
		if (v < $signed({2'b00, PULSE_LOW})) r = PULSE_LOW;
		else if (v > $signed({2'b00, PULSE_HIGH})) r = PULSE_HIGH;
		else r = v[11:0];
		return r;
	endfunction

	// box center offsets against the source center, doubled to stay integral
	logic [19:0] sh, sw;
	logic [20:0] sh2, sw2;
	logic [17:0] sum_y, sum_x;
	logic signed [21:0] ty, tx;
	logic [21:0] ty_abs, tx_abs;
	logic ty_neg, tx_neg;

	assign sh    = 20'(src_h_q) << FRAC_BITS;
	assign sw    = 20'(src_w_q) << FRAC_BITS;
	assign sh2   = {sh, 1'b0};
	assign sw2   = {sw, 1'b0};
	assign sum_y = {1'b0, by_q, 1'b0} + {2'b00, bh_q};
	assign sum_x = {1'b0, bx_q, 1'b0} + {2'b00, bw_q};
	assign ty    = $signed({4'b0000, sum_y}) - $signed({2'b00, sh});
	assign tx    = $signed({4'b0000, sum_x}) - $signed({2'b00, sw});
	assign ty_neg = ty[21];
	assign tx_neg = tx[21];
	assign ty_abs = ty_neg ? (22'd0 - ty) : ty;
	assign tx_abs = tx_neg ? (22'd0 - tx) : tx;

	// interpolation inputs
	logic [31:0] elapsed;
	logic signed [12:0] dsig;
	logic [12:0] dabs;
	logic est_active;

	assign elapsed    = now_q - mst_q;
	assign dsig       = $signed({1'b0, goal_q}) - $signed({1'b0, origin_q});
	assign dabs       = dsig[12] ? (13'd0 - dsig) : dsig;
	assign est_active = moving_q && (mlen_q != 16'd0) && (origin_q != goal_q);

	// round half up: floor((2*num + L) / 2L); negative num folds into a ceiling
	assign div_start = (state_q == ST_EST_MUL);
	assign div_num   = DIV_N_W'({prod_q[26:0], 1'b0}) + DIV_N_W'(mlen_q)
		- DIV_N_W'(dneg_q);
	assign div_den   = {mlen_q, 1'b0};

	logic signed [13:0] q_s, interp;
	assign q_s    = dneg_q ? (14'sd0 - $signed({2'b00, div_quo})) : $signed({2'b00, div_quo});
	assign interp = $signed({2'b00, origin_q}) + q_s;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_AREA: begin
				mul_a = MUL_A_W'(cur_w_q);
				mul_b = cur_h_q;
			end
			ST_EST: begin
				mul_a = MUL_A_W'(elapsed[15:0]);
				mul_b = MUL_B_W'(dabs[11:0]);
			end
			ST_GEO: begin
				case (step_q)
					GS_EY:  begin mul_a = MUL_A_W'(ty_abs[20:0]); mul_b = DH; end
					GS_EX:  begin mul_a = MUL_A_W'(tx_abs[20:0]); mul_b = DW; end
					GS_DZY: begin mul_a = MUL_A_W'(sh2); mul_b = MUL_B_W'(pan_dz_q); end
					GS_DZX: begin mul_a = MUL_A_W'(sw2); mul_b = MUL_B_W'(pan_dz_q); end
					GS_SBY: begin mul_a = MUL_A_W'(sh2); mul_b = MUL_B_W'(start_band_q); end
					GS_GW0: begin mul_a = MUL_A_W'(bw_q); mul_b = DW; end
					GS_GW1: begin mul_a = MUL_A_W'(prod_q[27:0]); mul_b = MUL_B_W'(src_h_q); end
					GS_GH0: begin mul_a = MUL_A_W'(bh_q); mul_b = DH; end
					GS_GH1: begin mul_a = MUL_A_W'(prod_q[27:0]); mul_b = MUL_B_W'(src_w_q); end
					GS_SS:  begin mul_a = MUL_A_W'(sh2); mul_b = MUL_B_W'(src_w_q); end
					GS_TSS: begin
						mul_a = MUL_A_W'(prod_q[32:0]);
						mul_b = MUL_B_W'(target_size_q);
					end
					GS_DZS: begin mul_a = MUL_A_W'(ss_q); mul_b = MUL_B_W'(size_dz_q); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// tracking decisions, all exact integer compares
	logic stop_only, tgt_hi, tgt_lo, has_tgt, settled, in_band;
	logic want_stop, do_stop, do_set, ex_hi, ex_lo, fwd, back, chs_change;
	logic [11:0] tgt_val;
	logic [43:0] sum_gd, sum_td;
	logic signed [1:0] turn_c, vx_c, nx_drive, nx_steer;

	assign stop_only = (op_q == OP_EMPTY) || (src_w_q == 12'd0) || (src_h_q == 12'd0);
	assign tgt_hi    = !ty_neg && (ey_mag_q > 33'(dzy_q));
	assign tgt_lo    = ty_neg && (ey_mag_q > 33'(dzy_q));
	assign has_tgt   = tgt_hi || tgt_lo;
	assign tgt_val   = tgt_hi ? PULSE_HIGH : PULSE_LOW;
	assign settled   = !stop_pend_q || ((now_q - stop_time_q) >= 32'(settle_q));
	assign in_band   = ey_mag_q < 33'(sby_q);
	assign want_stop = stop_only || !has_tgt || (moving_q && (tgt_val != goal_q));
	assign do_stop   = want_stop && moving_q;
	assign do_set    = !want_stop && !moving_q && settled && !in_band && (tgt_val != pos_q);

	assign ex_hi  = !tx_neg && (ex_mag_q > 33'(dzx_q));
	assign ex_lo  = tx_neg && (ex_mag_q > 33'(dzx_q));
	assign sum_gd = 44'(g_q) + 44'(dzs_q);
	assign sum_td = 44'(tss_q) + 44'(dzs_q);
	assign fwd    = 44'(tss_q) > sum_gd;
	assign back   = 44'(g_q) > sum_td;
	assign turn_c = ex_hi ? DIR_POS : (ex_lo ? DIR_NEG : DIR_NONE);
	assign vx_c   = fwd ? DIR_POS : (back ? DIR_NEG : DIR_NONE);

	// a turn in progress keeps turning, a drive keeps driving, turning wins otherwise
	always_comb begin
		nx_drive = DIR_NONE;
		nx_steer = DIR_NONE;
		if (stop_only) begin
			nx_drive = DIR_NONE;
		end else if (steer_q != DIR_NONE) begin
			nx_steer = turn_c;
		end else if (drive_q != DIR_NONE) begin
			nx_drive = vx_c;
		end else if (turn_c != DIR_NONE) begin
			nx_steer = turn_c;
		end else begin
			nx_drive = vx_c;
		end
	end

	assign chs_change = (nx_drive != drive_q) || (nx_steer != steer_q);

	// load the result register when the sequencer is done and the slot is free or taken
	assign emit_fire = (state_q == ST_EMIT) && (!res_valid_q || result.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_dz_q      <= 8'd25;
			start_band_q  <= 8'd40;
			target_size_q <= 10'd160;
			size_dz_q     <= 8'd20;
			settle_q      <= 16'd300;
			move_dur_q    <= 16'd8000;
			src_w_q       <= 12'd192;
			src_h_q       <= 12'd192;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAN_DZ:    pan_dz_q      <= cfg_data[7:0];
				CFG_START_BND: start_band_q  <= cfg_data[7:0];
				CFG_TGT_SIZE:  target_size_q <= cfg_data[9:0];
				CFG_SIZE_DZ:   size_dz_q     <= cfg_data[7:0];
				CFG_SETTLE:    settle_q      <= cfg_data;
				CFG_MOVE_DUR:  move_dur_q    <= cfg_data;
				CFG_SRC_W:     src_w_q       <= cfg_data[11:0];
				CFG_SRC_H:     src_h_q       <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// sequencer, tracking state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= GS_EY;
			top_area_q  <= '0;
			has_box_q   <= 1'b0;
			bx_q        <= '0;
			by_q        <= '0;
			bw_q        <= '0;
			bh_q        <= '0;
			pos_q       <= PULSE_HOME;
			origin_q    <= PULSE_HOME;
			goal_q      <= PULSE_HOME;
			mst_q       <= '0;
			mlen_q      <= '0;
			moving_q    <= 1'b0;
			stop_time_q <= '0;
			stop_pend_q <= 1'b0;
			drive_q     <= DIR_NONE;
			steer_q     <= DIR_NONE;
			srv_cmd_q   <= 1'b0;
			chs_cmd_q   <= 1'b0;
			srv_ms_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_fire) res_valid_q <= 1'b1;
			else if (result.valid && result.ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						op_q      <= item.op;
						cur_x_q   <= item.box_x;
						cur_y_q   <= item.box_y;
						cur_w_q   <= item.box_w;
						cur_h_q   <= item.box_h;
						last_q    <= item.last_box;
						now_q     <= item.now_ms;
						srv_cmd_q <= 1'b0;
						chs_cmd_q <= 1'b0;
						srv_ms_q  <= '0;
						case (item.op)
							OP_BOX: state_q <= ST_AREA;
							OP_EMPTY: begin
								top_area_q <= '0;
								has_box_q  <= 1'b0;
								state_q    <= ST_EST;
							end
							OP_HOME: begin
								top_area_q  <= '0;
								has_box_q   <= 1'b0;
								chs_cmd_q   <= 1'b1;
								drive_q     <= DIR_NONE;
								steer_q     <= DIR_NONE;
								srv_cmd_q   <= 1'b1;
								srv_ms_q    <= HOME_MS;
								pos_q       <= PULSE_HOME;
								origin_q    <= PULSE_HOME;
								goal_q      <= PULSE_HOME;
								mst_q       <= item.now_ms;
								mlen_q      <= HOME_MS;
								moving_q    <= 1'b0;
								stop_pend_q <= 1'b0;
								state_q     <= ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_AREA: state_q <= ST_BEST;
				ST_BEST: begin
					// keep the first of equal areas
					if (!has_box_q || (prod_q[31:0] > top_area_q)) begin
						top_area_q <= prod_q[31:0];
						has_box_q  <= 1'b1;
						bx_q       <= cur_x_q;
						by_q       <= cur_y_q;
						bw_q       <= cur_w_q;
						bh_q       <= cur_h_q;
					end
					state_q <= last_q ? ST_EST : ST_IDLE;
				end
				ST_EST: begin
					step_q <= GS_EY;
					if (!est_active) begin
						state_q <= stop_only ? ST_DECIDE : ST_GEO;
					end else if (elapsed >= 32'(mlen_q)) begin
						pos_q    <= goal_q;
						moving_q <= 1'b0;
						// a stop request on a move that just ran out still starts the settle time
						if (stop_only) begin
							stop_time_q <= now_q;
							stop_pend_q <= 1'b1;
						end
						state_q  <= stop_only ? ST_DECIDE : ST_GEO;
					end else begin
						dneg_q  <= dsig[12];
						state_q <= ST_EST_MUL;
					end
				end
				ST_EST_MUL: state_q <= ST_EST_DIV;
				ST_EST_DIV: begin
					if (div_done) begin
						pos_q   <= clamp_pulse(interp);
						state_q <= stop_only ? ST_DECIDE : ST_GEO;
					end
				end
				ST_GEO: begin
					// capture the product issued one step earlier
					step_q <= step_q + 4'd1;
					case (step_q)
						GS_EX:  ey_mag_q <= prod_q[32:0];
						GS_DZY: ex_mag_q <= prod_q[32:0];
						GS_DZX: dzy_q    <= prod_q[28:0];
						GS_SBY: dzx_q    <= prod_q[28:0];
						GS_GW0: sby_q    <= prod_q[28:0];
						GS_GH0: g_q      <= 41'(prod_q[39:0]);
						GS_SS:  g_q      <= g_q + 41'(prod_q[39:0]);
						GS_TSS: ss_q     <= prod_q[32:0];
						GS_DZS: tss_q    <= prod_q[42:0];
						GS_END: begin
							dzs_q   <= prod_q[40:0];
							state_q <= ST_DECIDE;
						end
						default: ;
					endcase
				end
				ST_DECIDE: begin
					if (do_stop) begin
						// hold at the estimate for a short move, then settle
						srv_cmd_q   <= 1'b1;
						srv_ms_q    <= HOLD_MS;
						origin_q    <= pos_q;
						goal_q      <= pos_q;
						mst_q       <= now_q;
						mlen_q      <= HOLD_MS;
						moving_q    <= 1'b0;
						stop_time_q <= now_q;
						stop_pend_q <= 1'b1;
					end else if (do_set) begin
						srv_cmd_q <= 1'b1;
						srv_ms_q  <= move_dur_q;
						origin_q  <= pos_q;
						goal_q    <= tgt_val;
						mst_q     <= now_q;
						mlen_q    <= move_dur_q;
						moving_q  <= move_dur_q > HOLD_MS;
						if (move_dur_q > HOLD_MS) stop_pend_q <= 1'b0;
					end
					if (chs_change) begin
						chs_cmd_q <= 1'b1;
						drive_q   <= nx_drive;
						steer_q   <= nx_steer;
					end
					top_area_q <= '0;
					has_box_q  <= 1'b0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						res_srv_q   <= srv_cmd_q;
						res_goal_q  <= goal_q;
						res_ms_q    <= srv_ms_q;
						res_chs_q   <= chs_cmd_q;
						res_drive_q <= drive_q;
						res_steer_q <= steer_q;
						res_est_q   <= pos_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item.ready               = (state_q == ST_IDLE);
	assign result.valid             = res_valid_q;
	assign result.servo_cmd_valid   = res_srv_q;
	assign result.servo_goal_us     = res_goal_q;
	assign result.servo_move_ms     = res_ms_q;
	assign result.chassis_cmd_valid = res_chs_q;
	assign result.drive_dir         = res_drive_q;
	assign result.steer_dir         = res_steer_q;
	assign result.servo_estimate_us = res_est_q;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q >= PULSE_LOW) && (pos_q <= PULSE_HIGH))
		else $error("servo estimate out of pulse range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && (item.op != OP_IGNORED)) |=> !item.ready)
		else $error("request taken while previous one still in work");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_EST_DIV))
		else $error("divider finished outside interpolation");

	a_one_chassis_axis: assert property (@(posedge clk) disable iff (!arst_n)
		!((drive_q != DIR_NONE) && (steer_q != DIR_NONE)))
		else $error("chassis drives and turns at once");
`endif

endmodule

// File: rtl/gbt_mul.sv
// Shared unsigned multiplier with a registered product.
module gbt_mul import gbt_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// File: rtl/gbt_div.sv
// Restoring divider, one quotient bit per cycle.
module gbt_div import gbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic               done,
	output logic [DIV_Q_W-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_Q_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_Q_W-1:0] bits_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   diff;
	logic               fits;

	assign trial = {rem_q, bits_q[DIV_Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_Q_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// the top bits of the dividend start below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[DIV_N_W-1:DIV_Q_W];
			bits_q <= num[DIV_Q_W-1:0];
			den_q  <= den;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			bits_q <= bits_q << 1;
			quo_q  <= {quo_q[DIV_Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: test/gesture_box_tracking_controller_tb.sv
// Testbench for the gesture box tracking controller: directed table, random frames, predictor.
module gesture_box_tracking_controller_tb import gbt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DISP_W     = 400;
	localparam int DISP_H     = 320;
	localparam int FRAC       = 4;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYC  = 60;

	typedef struct packed {
		logic              servo_cmd;
		logic [11:0]       goal_us;
		logic [15:0]       move_ms;
		logic              chassis_cmd;
		logic signed [1:0] drive;
		logic signed [1:0] steer;
		logic [11:0]       est_us;
	} cmd_t;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] x, y, w, h;
		logic        last;
		logic [31:0] t;
		bit          typed;
		cmd_t        known;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	gbt_item_if item_ch();
	gbt_result_if res_ch();

	gesture_box_tracking_controller u_top (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// expected commands, oldest first
	cmd_t cmd_q[$];
	bit failed = 0;
	int idle_cycles = 0;
	bit hold_go = 0;

	// tracker state mirror
	int unsigned cfg_reg[8];
	int unsigned top_area;
	int unsigned bb_x, bb_y, bb_w, bb_h;
	bit has_box;
	int pos, org, goal;
	int unsigned mv_start, mv_len, stop_t;
	bit moving, stop_pend;
	int drv, str;
	bit srv_cmd, chs_cmd;
	int unsigned srv_goal, srv_ms;

	function automatic int clamp_pulse(longint v);
		if (v < 500) return 500;
		if (v > 2500) return 2500;
		return int'(v);
	endfunction

	// interpolated pulse, halves rounded up; the move ends once its time ran out
	function automatic int servo_estimate(int unsigned now);
		int unsigned el;
		longint num, den, n2, q;
		if (!moving || mv_len == 0 || org == goal) return pos;
		el = now - mv_start;
		if (el >= mv_len) begin
			pos = goal;
			moving = 0;
			return pos;
		end
		num = longint'(goal - org) * longint'(el);
		den = 2 * longint'(mv_len);
		n2 = 2 * num + longint'(mv_len);
		q = (n2 >= 0) ? n2 / den : -((-n2 + den - 1) / den);
		pos = clamp_pulse(longint'(org) + q);
		return pos;
	endfunction

	function automatic void servo_goto(int target, int unsigned dur, int unsigned now);
		int from;
		from = servo_estimate(now);
		target = clamp_pulse(target);
		if (target == from && !moving) return;
		srv_cmd = 1;
		srv_goal = target;
		srv_ms = dur;
		pos = from;
		org = from;
		goal = target;
		mv_start = now;
		mv_len = dur;
		moving = (target != from) && (dur > 20);
		if (moving) stop_pend = 0;
	endfunction

	function automatic void servo_halt(int unsigned now);
		if (!moving) return;
		servo_goto(servo_estimate(now), 20, now);
		stop_t = now;
		stop_pend = 1;
	endfunction

	function automatic void chassis_go(int vx, int turn);
		if (turn != 0) vx = 0;
		if (vx == drv && turn == str) return;
		chs_cmd = 1;
		drv = vx;
		str = turn;
	endfunction

	function automatic void track_box(int unsigned now);
		longint bx, by, bw, bh, sw, sh, ey, ex, dzy, dzx, sby, g, ss, err, dzs;
		int tgt, turn, vx;
		bit hold_off;
		if (cfg_reg[CFG_SRC_W] == 0 || cfg_reg[CFG_SRC_H] == 0) begin
			chassis_go(0, 0);
			servo_halt(now);
			return;
		end
		bx = bb_x; by = bb_y; bw = bb_w; bh = bb_h;
		sw = longint'(cfg_reg[CFG_SRC_W]) << FRAC;
		sh = longint'(cfg_reg[CFG_SRC_H]) << FRAC;
		ey = (2 * by + bh) * DISP_H - DISP_H * sh;
		ex = (2 * bx + bw) * DISP_W - DISP_W * sw;
		dzy = longint'(cfg_reg[CFG_PAN_DZ]) * 2 * sh;
		dzx = longint'(cfg_reg[CFG_PAN_DZ]) * 2 * sw;
		sby = longint'(cfg_reg[CFG_START_BND]) * 2 * sh;
		void'(servo_estimate(now));
		tgt = 0;
		if (ey > dzy) tgt = 2500;
		else if (ey < -dzy) tgt = 500;
		hold_off = stop_pend && ((now - stop_t) < cfg_reg[CFG_SETTLE]);
		if (tgt == 0) servo_halt(now);
		else if (moving && tgt != goal) servo_halt(now);
		else if (!moving && (hold_off || (ey < sby && ey > -sby))) ;
		else if (!moving || tgt != goal) servo_goto(tgt, cfg_reg[CFG_MOVE_DUR], now);
		turn = 0;
		if (ex > dzx) turn = 1;
		else if (ex < -dzx) turn = -1;
		g = bw * DISP_W * longint'(cfg_reg[CFG_SRC_H])
			+ bh * DISP_H * longint'(cfg_reg[CFG_SRC_W]);
		ss = 2 * longint'(cfg_reg[CFG_SRC_W]) * sh;
		err = longint'(cfg_reg[CFG_TGT_SIZE]) * ss - g;
		dzs = longint'(cfg_reg[CFG_SIZE_DZ]) * ss;
		vx = 0;
		if (err > dzs) vx = 1;
		else if (err < -dzs) vx = -1;
		if (str != 0) chassis_go(0, turn);
		else if (drv != 0) chassis_go(vx, 0);
		else if (turn != 0) chassis_go(0, turn);
		else chassis_go(vx, 0);
	endfunction

	function automatic void drop_frame();
		top_area = 0;
		{bb_x, bb_y, bb_w, bb_h} = '0;
		has_box = 0;
	endfunction

	// advance the mirror by one request; returns 1 when a command result follows
	function automatic bit tracker_step(logic [1:0] op, logic [15:0] x, y, w, h, logic last,
			logic [31:0] now, output cmd_t r);
		int unsigned area;
		srv_cmd = 0; chs_cmd = 0; srv_goal = 0; srv_ms = 0;
		r = '0;
		case (op)
			OP_BOX: begin
				area = w * h;
				if (!has_box || area > top_area) begin
					top_area = area;
					bb_x = x; bb_y = y; bb_w = w; bb_h = h;
					has_box = 1;
				end
				if (!last) return 0;
				track_box(now);
				drop_frame();
			end
			OP_EMPTY: begin
				drop_frame();
				chassis_go(0, 0);
				servo_halt(now);
			end
			OP_HOME: begin
				drop_frame();
				chs_cmd = 1; drv = 0; str = 0;
				srv_cmd = 1; srv_goal = 1500; srv_ms = 500;
				pos = 1500; org = 1500; goal = 1500;
				mv_start = now; mv_len = 500;
				moving = 0; stop_pend = 0;
			end
			default: return 0;
		endcase
		r.servo_cmd = srv_cmd;
		r.goal_us = srv_cmd ? srv_goal[11:0] : goal[11:0];
		r.move_ms = srv_cmd ? srv_ms[15:0] : 16'd0;
		r.chassis_cmd = chs_cmd;
		r.drive = drv[1:0];
		r.steer = str[1:0];
		r.est_us = pos[11:0];
		return 1;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cfg_we = 0; cfg_index = CFG_PAN_DZ; cfg_data = 0;
		item_ch.valid = 0; item_ch.op = OP_BOX; item_ch.box_x = 0; item_ch.box_y = 0;
		item_ch.box_w = 0; item_ch.box_h = 0; item_ch.last_box = 0; item_ch.now_ms = 0;
		res_ch.ready = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// reset values of the registers and of the tracker
	initial begin
		cfg_reg = '{25, 40, 160, 20, 300, 8000, 192, 192};
		drop_frame();
		pos = 1500; org = 1500; goal = 1500;
		mv_start = 0; mv_len = 0; moving = 0; stop_t = 0; stop_pend = 0;
		drv = 0; str = 0;
	end

	// result side: check, then pick the next stall
	int rx_mode = 0, rx_left = 0, hold_left = 0;
	always @(posedge clk) begin
		cmd_t got, want;
		if (res_ch.valid && res_ch.ready) begin
			got = {res_ch.servo_cmd_valid, res_ch.servo_goal_us, res_ch.servo_move_ms,
				res_ch.chassis_cmd_valid, res_ch.drive_dir, res_ch.steer_dir,
				res_ch.servo_estimate_us};
			if (cmd_q.size() == 0) begin
				$error("result with nothing expected");
				failed = 1;
			end else begin
				want = cmd_q.pop_front();
				if (got.servo_cmd !== want.servo_cmd) begin
					$error("servo_cmd_valid exp %0d got %0d", want.servo_cmd, got.servo_cmd); failed = 1;
				end
				if (got.goal_us !== want.goal_us) begin
					$error("servo_goal_us exp %0d got %0d", want.goal_us, got.goal_us); failed = 1;
				end
				if (got.move_ms !== want.move_ms) begin
					$error("servo_move_ms exp %0d got %0d", want.move_ms, got.move_ms); failed = 1;
				end
				if (got.chassis_cmd !== want.chassis_cmd) begin
					$error("chassis_cmd_valid exp %0d got %0d", want.chassis_cmd, got.chassis_cmd);
					failed = 1;
				end
				if (got.drive !== want.drive) begin
					$error("drive_dir exp %0d got %0d", want.drive, got.drive); failed = 1;
				end
				if (got.steer !== want.steer) begin
					$error("steer_dir exp %0d got %0d", want.steer, got.steer); failed = 1;
				end
				if (got.est_us !== want.est_us) begin
					$error("servo_estimate_us exp %0d got %0d", want.est_us, got.est_us); failed = 1;
				end
			end
		end
		// long hold-off on request, otherwise a stall pattern that changes every so often
		if (hold_go) begin
			hold_go = 0;
			hold_left = 400;
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 96);
		end else rx_left--;
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 0;
		end else case (rx_mode)
			0: res_ch.ready <= 1;
			1: res_ch.ready <= ($urandom_range(0, 2) == 0);
			2: res_ch.ready <= (rx_left % 8 < 2);
			default: res_ch.ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("gesture_box_tracking_controller: mismatch");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	// request side
	int burst_left = 0;
	bit gaps_on = 1;
	logic [31:0] clock_ms;

	task automatic send_req(logic [1:0] op, logic [15:0] x, y, w, h, logic last,
			logic [31:0] now, bit typed = 0, cmd_t known = '0);
		cmd_t r;
		int gap;
		item_ch.valid <= 1;
		item_ch.op <= op; item_ch.box_x <= x; item_ch.box_y <= y;
		item_ch.box_w <= w; item_ch.box_h <= h; item_ch.last_box <= last; item_ch.now_ms <= now;
		do @(posedge clk); while (!item_ch.ready);
		if (tracker_step(op, x, y, w, h, last, now, r))
			cmd_q.push_back(typed ? known : r);
		// advance the burst; drop valid for a gap between bursts
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 12);
			gap = gaps_on ? $urandom_range(1, 8) : 0;
			if (gap > 0) begin
				item_ch.valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// let every result arrive and the block finish silent work before touching registers
	task automatic quiesce();
		item_ch.valid <= 0;
		@(posedge clk);
		while (cmd_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// the caller drops cfg_we after its last write
	task automatic write_reg(logic [2:0] idx, int unsigned val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val[15:0];
		@(posedge clk);
		case (idx)
			CFG_PAN_DZ, CFG_START_BND, CFG_SIZE_DZ: cfg_reg[idx] = val & 32'hFF;
			CFG_TGT_SIZE: cfg_reg[idx] = val & 32'h3FF;
			CFG_SRC_W, CFG_SRC_H: cfg_reg[idx] = val & 32'hFFF;
			default: cfg_reg[idx] = val & 32'hFFFF;
		endcase
	endtask

	function automatic logic [15:0] coord(int unsigned span);
		if ($urandom_range(0, 9) == 0 || span == 0) return 16'($urandom);
		return 16'($urandom_range(0, span));
	endfunction

	row_t rows[$];
	initial begin
		cmd_t home_res, still_res;
		row_t rw;
		int unsigned sw_q, sh_q, n;
		int sent;
		home_res = '{1'b1, PULSE_HOME, HOME_MS, 1'b1, DIR_NONE, DIR_NONE, PULSE_HOME};
		still_res = '{1'b0, PULSE_HOME, 16'd0, 1'b0, DIR_NONE, DIR_NONE, PULSE_HOME};
		// directed table; the source space is 192x192, so the frame center is 1536 in Q12.4
		rows = '{
			'{OP_EMPTY,   0, 0, 0, 0, 1, 100, 1, still_res},
			'{OP_HOME,    0, 0, 0, 0, 0, 200, 1, home_res},
			'{OP_IGNORED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 250, 0, '0},
			'{OP_BOX, 2816, 2816, 512, 512, 1, 300, 0, '0},
			'{OP_BOX, 2816, 0, 512, 256, 1, 1000, 0, '0},
			'{OP_BOX, 2816, 2800, 512, 272, 1, 2000, 0, '0},
			'{OP_BOX, 2816, 2800, 512, 272, 1, 2100, 0, '0},
			'{OP_BOX, 2816, 2800, 512, 272, 1, 2500, 0, '0},
			'{OP_BOX, 100, 100, 64, 64, 0, 2600, 0, '0},
			'{OP_BOX, 2000, 2600, 800, 800, 0, 2600, 0, '0},
			'{OP_BOX, 0, 0, 640, 1000, 1, 2700, 0, '0},
			'{OP_BOX, 0, 2816, 0, 512, 1, 3000, 0, '0},
			'{OP_BOX, 16'hFFFF, 2816, 16'hFFFF, 512, 1, 3500, 0, '0},
			'{OP_BOX, 0, 0, 16'hFFFF, 16'hFFFF, 1, 4000, 0, '0},
			'{OP_BOX, 3000, 3000, 32, 32, 1, 6000, 0, '0},
			'{OP_EMPTY, 0, 0, 0, 0, 0, 6100, 0, '0},
			'{OP_BOX, 3000, 3000, 900, 900, 0, 6200, 0, '0},
			'{OP_EMPTY, 0, 0, 0, 0, 1, 6300, 0, '0},
			'{OP_BOX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 32'hFFFF_FFF0, 0, '0},
			'{OP_BOX, 2816, 0, 512, 256, 1, 32'h0000_0100, 0, '0},
			'{OP_HOME, 0, 0, 0, 0, 1, 32'h0000_0200, 0, '0}
		};
		@(posedge arst_n);
		@(posedge clk);
		foreach (rows[i]) begin
			rw = rows[i];
			send_req(rw.op, rw.x, rw.y, rw.w, rw.h, rw.last, rw.t, rw.typed, rw.known);
		end
		clock_ms = $urandom;
		// phases of random traffic, each under its own register setting
		for (int ph = 0; ph < 9; ph++) begin
			quiesce();
			for (int i = 0; i < 8; i++) begin
				case (ph)
					1: write_reg(i[2:0], 0);
					2: write_reg(i[2:0], 16'hFFFF);
					3: write_reg(i[2:0], (i >= 6) ? 4095 : (i == 4 || i == 5) ? 21 : 255);
					default: case (i)
						4: write_reg(i[2:0], $urandom_range(0, 600));
						5: write_reg(i[2:0], $urandom_range(0, 4) == 0 ?
							$urandom_range(0, 65535) : $urandom_range(0, 3000));
						6, 7: write_reg(i[2:0], $urandom_range(0, 9) == 0 ?
							$urandom_range(0, 4095) : $urandom_range(64, 640));
						2: write_reg(i[2:0], $urandom_range(0, 1023));
						default: write_reg(i[2:0], $urandom_range(0, 255));
					endcase
				endcase
			end
			cfg_we <= 0;
			gaps_on = (ph % 3 != 0);
			if (ph == 4) hold_go = 1;
			sw_q = cfg_reg[CFG_SRC_W] << FRAC;
			sh_q = cfg_reg[CFG_SRC_H] << FRAC;
			if (sw_q > 65535) sw_q = 65535;
			if (sh_q > 65535) sh_q = 65535;
			sent = 0;
			while (sent < 170) begin
				clock_ms += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 70000) :
					$urandom_range(0, 400);
				n = $urandom_range(0, 99);
				if (n < 6) send_req(OP_EMPTY, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom), clock_ms);
				else if (n < 10) send_req(OP_HOME, 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 1'($urandom), clock_ms);
				else if (n < 13) begin
					send_req(OP_IGNORED, 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 1'($urandom), clock_ms);
					sent--;
				end else if (n < 17) send_req(OP_BOX, 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 1'($urandom), clock_ms);
				else begin
					// well-formed frame of one to four boxes
					n = $urandom_range(1, 4);
					for (int b = 1; b <= n; b++) begin
						send_req(OP_BOX, coord(sw_q), coord(sh_q), coord(sw_q / 2),
							coord(sh_q / 2), b == n, clock_ms);
						sent++;
					end
					sent--;
				end
				sent++;
			end
		end
		quiesce();
		repeat (DRAIN_CYC) @(posedge clk);
		if (!failed && cmd_q.size() == 0)
			$display("gesture_box_tracking_controller: match");
		else
			$display("gesture_box_tracking_controller: mismatch");
		$finish;
	end

endmodule
